// ----- src/panel_motor_alarm_controller_macros.svh -----
// Assertion macros for the panel, motor and alarm controller.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef PANEL_MOTOR_ALARM_CONTROLLER_MACROS_SVH
`define PANEL_MOTOR_ALARM_CONTROLLER_MACROS_SVH

// Property checked outside reset.
`define PMAC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PMAC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/pmac_pkg.sv -----
// Shared types, codes and constants of the panel, motor and alarm controller.
// No dependencies; all modules of the controller import this package.
`timescale 1ns / 1ps
`default_nettype none

package pmac_pkg;

   // Input operation codes.
   localparam logic [1:0] OPC_KEY     = 2'd0;
   localparam logic [1:0] OPC_SAMPLE  = 2'd1;
   localparam logic [1:0] OPC_COMMAND = 2'd2;

   // Key codes.
   localparam logic [3:0] KC_LED     = 4'd1;
   localparam logic [3:0] KC_BEEP    = 4'd2;
   localparam logic [3:0] KC_RELAY   = 4'd3;
   localparam logic [3:0] KC_ENABLE  = 4'd4;
   localparam logic [3:0] KC_UP      = 4'd5;
   localparam logic [3:0] KC_DOWN    = 4'd6;
   localparam logic [3:0] KC_FORWARD = 4'd7;
   localparam logic [3:0] KC_REVERSE = 4'd8;
   localparam logic [3:0] KC_PAUSE   = 4'd9;

   // Command direction code that selects reverse.
   localparam logic [1:0] DIR_REVERSE = 2'd1;

   // Bit positions in the command valid mask and flag bits.
   localparam int unsigned VM_LED    = 0;
   localparam int unsigned VM_BEEP   = 1;
   localparam int unsigned VM_RELAY  = 2;
   localparam int unsigned VM_ENABLE = 3;
   localparam int unsigned VM_DIR    = 4;
   localparam int unsigned VM_SPEED  = 5;
   localparam int unsigned VM_CLEAR  = 6;
   localparam int unsigned FB_LED    = 0;
   localparam int unsigned FB_BEEP   = 1;
   localparam int unsigned FB_RELAY  = 2;
   localparam int unsigned FB_ENABLE = 3;
   localparam int unsigned FB_CLEAR  = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_ALARM_SET   = 2'd0;
   localparam logic [1:0] CSR_ALARM_CLEAR = 2'd1;
   localparam logic [1:0] CSR_PAUSE_TICKS = 2'd2;

   // Register reset values.
   localparam logic [11:0] ALARM_SET_RESET   = 12'd2500;
   localparam logic [11:0] ALARM_CLEAR_RESET = 12'd2400;
   localparam logic [31:0] PAUSE_TICKS_RESET = 32'd10000;

   localparam logic [7:0] MAX_SPEED = 8'd100;

   // Millivolt scaling: sample * 3000 / 4096, the divide being a shift.
   localparam int unsigned ADC_W  = 12;
   localparam int unsigned PROD_W = 24;
   localparam logic [PROD_W-1:0] MV_FULL_SCALE = 24'd3000;

   // Queue between the front and the back.
   localparam int unsigned Q_DEPTH = 4;   // power of two
   localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
   localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_KEY,
      OP_SAMPLE,
      OP_COMMAND,
      OP_NONE
   } op_type;

   typedef enum logic [3:0] {
      KEY_NONE,
      KEY_LED,
      KEY_BEEP,
      KEY_RELAY,
      KEY_ENABLE,
      KEY_UP,
      KEY_DOWN,
      KEY_FORWARD,
      KEY_REVERSE,
      KEY_PAUSE
   } key_action_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      op_type         op;
      key_action_type key;
      logic [31:0]    now_ms;
      logic [11:0]    mv;
      logic [6:0]     valid_mask;
      logic [4:0]     flag_bits;
      logic           reverse;
      logic [7:0]     speed;
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

endpackage

`default_nettype wire

// ----- src/pmac_ifs.sv -----
// Channel interfaces of the panel, motor and alarm controller: request,
// response and configuration write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pmac_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] now_ms;
   logic [3:0]  key_code;
   logic [11:0] adc_sample;
   logic [6:0]  valid_mask;
   logic [4:0]  flag_bits;
   logic [1:0]  cmd_direction;
   logic [7:0]  cmd_speed;

   modport source (output valid, operation, now_ms, key_code, adc_sample, valid_mask,
                   flag_bits, cmd_direction, cmd_speed, input ready);
   modport sink   (input valid, operation, now_ms, key_code, adc_sample, valid_mask,
                   flag_bits, cmd_direction, cmd_speed, output ready);
endinterface

interface pmac_rsp_if;
   logic        valid;
   logic        ready;
   logic        led_on;
   logic        beeper_on;
   logic        relay_closed;
   logic        alarm_active;
   logic        motor_on;
   logic        motor_reverse;
   logic [7:0]  motor_level;
   logic [11:0] level_mv;

   modport source (output valid, led_on, beeper_on, relay_closed, alarm_active, motor_on,
                   motor_reverse, motor_level, level_mv, input ready);
   modport sink   (input valid, led_on, beeper_on, relay_closed, alarm_active, motor_on,
                   motor_reverse, motor_level, level_mv, output ready);
endinterface

interface pmac_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/pmac_front.sv -----
// Front end: accepts request items, decodes keys, scales samples to millivolts
// and saturates the command speed. Depends on pmac_pkg and pmac_ifs.
`timescale 1ns / 1ps
`default_nettype none

module pmac_front
   import pmac_pkg::*;
(
   pmac_req_if.sink    req,
   input  logic        q_full,
   output q_push_type  q_push
);

   logic [PROD_W-1:0] product;
   key_action_type    key_action;
   op_type            op;

   assign req.ready = !q_full;

   assign product = PROD_W'(req.adc_sample) * MV_FULL_SCALE;

   always_comb begin
      case (req.operation)
         OPC_KEY:     op = OP_KEY;
         OPC_SAMPLE:  op = OP_SAMPLE;
         OPC_COMMAND: op = OP_COMMAND;
         default:     op = OP_NONE;
      endcase
   end

   always_comb begin
      case (req.key_code)
         KC_LED:     key_action = KEY_LED;
         KC_BEEP:    key_action = KEY_BEEP;
         KC_RELAY:   key_action = KEY_RELAY;
         KC_ENABLE:  key_action = KEY_ENABLE;
         KC_UP:      key_action = KEY_UP;
         KC_DOWN:    key_action = KEY_DOWN;
         KC_FORWARD: key_action = KEY_FORWARD;
         KC_REVERSE: key_action = KEY_REVERSE;
         KC_PAUSE:   key_action = KEY_PAUSE;
         default:    key_action = KEY_NONE;
      endcase
   end

   always_comb begin
      q_push.push             = req.valid && !q_full;
      q_push.entry.op         = op;
      q_push.entry.key        = key_action;
      q_push.entry.now_ms     = req.now_ms;
      q_push.entry.mv         = product[PROD_W-1 -: ADC_W];
      q_push.entry.valid_mask = req.valid_mask;
      q_push.entry.flag_bits  = req.flag_bits;
      q_push.entry.reverse    = (req.cmd_direction == DIR_REVERSE);
      q_push.entry.speed      = (req.cmd_speed > MAX_SPEED) ? MAX_SPEED : req.cmd_speed;
   end

endmodule

`default_nettype wire

// ----- src/pmac_queue.sv -----
// Short queue of classified items between the front and the back end.
// Depends on pmac_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "panel_motor_alarm_controller_macros.svh"

module pmac_queue
   import pmac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_push_type q_push,
   input  logic       pop,
   output logic       q_full,
   output q_head_type q_head
);

   q_entry_type     slots_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] count_ff, count_in;
   logic            do_pop;

   assign q_full       = (count_ff == Q_CW'(Q_DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = slots_ff[rd_ptr_ff];
   assign do_pop       = pop && q_head.valid;

   always_comb begin
      wr_ptr_in = q_push.push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.push && !do_pop) begin
         count_in = count_ff + Q_CW'(1);
      end else if (do_pop && !q_push.push) begin
         count_in = count_ff - Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         slots_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   `PMAC_ASSERT(a_q_count_bound, count_ff <= Q_CW'(Q_DEPTH), "queue count above depth")
   `PMAC_ASSERT(a_q_no_overflow, q_push.push |-> (!q_full || do_pop), "push into full queue")
   `PMAC_ASSERT_RST(a_q_reset_empty, $past(reset) |-> (count_ff == '0), "queue not empty after reset")

endmodule

`default_nettype wire

// ----- src/pmac_back.sv -----
// Back end: holds the configuration and the panel, motor and alarm state,
// applies one item per cycle while the response register can take it and
// drives it. Depends on pmac_pkg, pmac_ifs and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "panel_motor_alarm_controller_macros.svh"

module pmac_back
   import pmac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_head_type q_head,
   output logic       pop,
   pmac_csr_if.sink   csr,
   pmac_rsp_if.source rsp
);

   logic [11:0] alarm_set_ff;
   logic [11:0] alarm_clear_ff;
   logic [31:0] pause_ticks_ff;

   logic        led_ff, led_in;
   logic        beep_ff, beep_in;
   logic        relay_ff, relay_in;
   logic        enable_ff, enable_in;
   logic        reverse_ff, reverse_in;
   logic [7:0]  speed_ff, speed_in;
   logic [11:0] mv_ff, mv_in;
   logic        alarm_ff, alarm_in;
   logic        pause_valid_ff, pause_valid_in;
   logic [31:0] deadline_ff, deadline_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_led_ff, rsp_beep_ff, rsp_relay_ff, rsp_alarm_ff;
   logic        rsp_enable_ff, rsp_reverse_ff;
   logic [7:0]  rsp_speed_ff;
   logic [11:0] rsp_mv_ff;

   logic [31:0] pause_end;
   logic [31:0] pause_left;
   q_entry_type item;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_set_ff   <= ALARM_SET_RESET;
         alarm_clear_ff <= ALARM_CLEAR_RESET;
         pause_ticks_ff <= PAUSE_TICKS_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_ALARM_SET:   alarm_set_ff   <= csr.data[11:0];
            CSR_ALARM_CLEAR: alarm_clear_ff <= csr.data[11:0];
            CSR_PAUSE_TICKS: pause_ticks_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // An item is taken when the response register is free or being emptied.
   assign pop  = q_head.valid && (!rsp_valid_ff || rsp.ready);
   assign item = q_head.entry;

   assign pause_end  = item.now_ms + pause_ticks_ff;
   assign pause_left = deadline_ff - item.now_ms;

   always_comb begin
      led_in         = led_ff;
      beep_in        = beep_ff;
      relay_in       = relay_ff;
      enable_in      = enable_ff;
      reverse_in     = reverse_ff;
      speed_in       = speed_ff;
      mv_in          = mv_ff;
      alarm_in       = alarm_ff;
      pause_valid_in = pause_valid_ff;
      deadline_in    = deadline_ff;
      if (pop) begin
         case (item.op)
            OP_KEY: begin
               case (item.key)
                  KEY_LED:     led_in   = !led_ff;
                  KEY_BEEP:    beep_in  = !beep_ff;
                  KEY_RELAY:   relay_in = !relay_ff;
                  KEY_ENABLE: begin
                     enable_in = !enable_ff;
                     if (!enable_ff && speed_ff == '0) begin
                        speed_in = 8'd1;
                     end
                  end
                  KEY_UP: begin
                     if (speed_ff < MAX_SPEED) begin
                        speed_in = speed_ff + 8'd1;
                     end
                  end
                  KEY_DOWN: begin
                     if (speed_ff != '0) begin
                        speed_in = speed_ff - 8'd1;
                     end
                  end
                  KEY_FORWARD: reverse_in = 1'b0;
                  KEY_REVERSE: reverse_in = 1'b1;
                  KEY_PAUSE: begin
                     deadline_in    = pause_end;
                     pause_valid_in = 1'b1;
                     alarm_in       = 1'b0;
                  end
                  default: ;
               endcase
            end
            OP_SAMPLE: begin
               mv_in = item.mv;
               if (item.mv >= alarm_set_ff) begin
                  // The pause runs while the deadline is less than half the
                  // time range ahead; once found expired it is dropped.
                  if (pause_valid_ff && !pause_left[31]) begin
                     alarm_in = 1'b0;
                  end else begin
                     alarm_in       = 1'b1;
                     pause_valid_in = 1'b0;
                     deadline_in    = '0;
                  end
               end else if (item.mv <= alarm_clear_ff) begin
                  alarm_in       = 1'b0;
                  pause_valid_in = 1'b0;
                  deadline_in    = '0;
               end
            end
            OP_COMMAND: begin
               if (item.valid_mask[VM_LED]) begin
                  led_in = item.flag_bits[FB_LED];
               end
               if (item.valid_mask[VM_BEEP]) begin
                  beep_in = item.flag_bits[FB_BEEP];
               end
               if (item.valid_mask[VM_RELAY]) begin
                  relay_in = item.flag_bits[FB_RELAY];
               end
               if (item.valid_mask[VM_ENABLE]) begin
                  enable_in = item.flag_bits[FB_ENABLE];
                  if (enable_in && speed_ff == '0) begin
                     speed_in = 8'd1;
                  end
               end
               if (item.valid_mask[VM_DIR]) begin
                  reverse_in = item.reverse;
               end
               if (item.valid_mask[VM_SPEED]) begin
                  speed_in = item.speed;
                  if (item.speed == '0) begin
                     enable_in = 1'b0;
                  end
               end
               if (item.valid_mask[VM_CLEAR] && item.flag_bits[FB_CLEAR]) begin
                  deadline_in    = pause_end;
                  pause_valid_in = 1'b1;
                  alarm_in       = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff         <= 1'b0;
         beep_ff        <= 1'b0;
         relay_ff       <= 1'b0;
         enable_ff      <= 1'b0;
         reverse_ff     <= 1'b0;
         speed_ff       <= '0;
         mv_ff          <= '0;
         alarm_ff       <= 1'b0;
         pause_valid_ff <= 1'b0;
         deadline_ff    <= '0;
      end else begin
         led_ff         <= led_in;
         beep_ff        <= beep_in;
         relay_ff       <= relay_in;
         enable_ff      <= enable_in;
         reverse_ff     <= reverse_in;
         speed_ff       <= speed_in;
         mv_ff          <= mv_in;
         alarm_ff       <= alarm_in;
         pause_valid_ff <= pause_valid_in;
         deadline_ff    <= deadline_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_led_ff     <= led_in;
         rsp_beep_ff    <= beep_in || alarm_in;
         rsp_relay_ff   <= relay_in;
         rsp_alarm_ff   <= alarm_in;
         rsp_enable_ff  <= enable_in;
         rsp_reverse_ff <= reverse_in;
         rsp_speed_ff   <= speed_in;
         rsp_mv_ff      <= mv_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.led_on        = rsp_led_ff;
   assign rsp.beeper_on     = rsp_beep_ff;
   assign rsp.relay_closed  = rsp_relay_ff;
   assign rsp.alarm_active  = rsp_alarm_ff;
   assign rsp.motor_on      = rsp_enable_ff;
   assign rsp.motor_reverse = rsp_reverse_ff;
   assign rsp.motor_level   = rsp_speed_ff;
   assign rsp.level_mv      = rsp_mv_ff;

   `PMAC_ASSERT(a_speed_limit, speed_ff <= MAX_SPEED, "motor speed above maximum")
   `PMAC_ASSERT(a_rsp_from_queue, $rose(rsp_valid_ff) |-> $past(q_head.valid), "response without item")

endmodule

`default_nettype wire

// ----- src/panel_motor_alarm_controller.sv -----
// Top level of the panel, motor and over-voltage alarm controller.
// Depends on pmac_pkg, pmac_ifs, pmac_front, pmac_queue and pmac_back.
`timescale 1ns / 1ps
`default_nettype none

// The controller keeps the LED, beeper, relay and DC motor state together
// with an over-voltage alarm, and returns the full status for every request
// item it accepts: a key event, an ADC sample or a remote command. It takes
// one item per clock cycle while its queue is not full. An accepted item waits
// in the queue and is applied when the back end pops it, and its status is
// loaded into the response register as it is applied. The front end decodes
// keys, scales a sample to millivolts with a single 12 by 12 bit multiply and
// saturates the command speed; a four-item queue then separates it from the
// back end, so request acceptance continues while a response waits.
// Throughput is set by the back end, which applies one item per cycle whenever
// the response register is empty or being read. Configuration writes are
// always accepted and are meant to happen while no item is in flight.

module panel_motor_alarm_controller
   import pmac_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   pmac_req_if.sink    req_bus,
   pmac_rsp_if.source  rsp_bus,
   pmac_csr_if.sink    csr_bus
);

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       pop;

   // Classification of request items.
   pmac_front u_front (
      .req    (req_bus),
      .q_full (q_full),
      .q_push (q_push)
   );

   // Decoupling queue between acceptance and execution.
   pmac_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   // State update, configuration registers and response register.
   pmac_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .pop    (pop),
      .csr    (csr_bus),
      .rsp    (rsp_bus)
   );

endmodule

`default_nettype wire
